// ===== sv/trrip_pkg.sv =====
// Shared types, widths and codes for the tiered RRIP replacement block.
`timescale 1ns / 1ps

package trrip_pkg;

   // Geometry of the prediction store
   localparam int NUM_WAYS  = 16;
   localparam int NUM_SETS  = 1024;
   localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W     = $clog2(NUM_WAYS);

   // Fixed field widths
   localparam int CMD_W      = 2;
   localparam int SET_IDX_W  = 10;
   localparam int WAY_IDX_W  = 4;
   localparam int TIER_W     = 2;
   localparam int RRPV_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Set reduction: reciprocal multiply, then one compare and subtract
   localparam int                  RECIP_SHIFT = 20;
   localparam int                  MOD_W       = 17;
   localparam int                  RECIP_W     = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0]  SET_RECIP   = RECIP_W'((1 << RECIP_SHIFT) / NUM_SETS);
   localparam logic [MOD_W-1:0]    SET_COUNT   = MOD_W'(NUM_SETS);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_FILL   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_HIT    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd3;

   // Reuse tier codes; anything else is the low tier
   localparam logic [TIER_W-1:0] TIER_HIGH = 2'd0;
   localparam logic [TIER_W-1:0] TIER_MOD  = 2'd1;

   // Prediction values
   localparam logic [RRPV_W-1:0] RRPV_RESET      = 3'd7;
   localparam logic [RRPV_W-1:0] RRPV_HIGH_FILL  = 3'd1;

   // Register map (byte addresses)
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_EVICT_LEVEL = 3'd0;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [RRPV_W-1:0]                rrpv_type;
   typedef rrpv_type [NUM_WAYS-1:0]           row_type;

   // Classified command word handed from front to back
   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [SET_W-1:0]     set;
      logic [WAY_IDX_W-1:0] way;
      logic [TIER_W-1:0]    tier;
      logic                 way_ok;
   } item_type;

endpackage

// ===== sv/trrip_front.sv =====
// Front end: accepts commands, reduces the set index and checks the way.
`timescale 1ns / 1ps

module trrip_front import trrip_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [SET_IDX_W-1:0]  req_set_index,
   input  logic [WAY_IDX_W-1:0]  req_way_index,
   input  logic [TIER_W-1:0]     req_tier,
   output logic                  push_valid,
   input  logic                  push_ready,
   output item_type              push_data
);

   logic                  hold_valid_ff, hold_valid_in;
   logic [CMD_W-1:0]      cmd_ff;
   logic [SET_IDX_W-1:0]  set_ff;
   logic [WAY_IDX_W-1:0]  way_ff;
   logic [TIER_W-1:0]     tier_ff;
   logic [SET_IDX_W-1:0]  quot_ff, quot_in;

   logic [SET_IDX_W+RECIP_W-1:0] recip_prod;
   logic [MOD_W+SET_IDX_W-1:0]   back_prod;
   logic [MOD_W-1:0]             rem_raw;
   logic [MOD_W-1:0]             rem_fix;
   logic                         accept;

   // Estimate the quotient at acceptance; it is low by at most one
   assign recip_prod = (SET_IDX_W+RECIP_W)'(req_set_index) * (SET_IDX_W+RECIP_W)'(SET_RECIP);
   assign quot_in    = recip_prod[RECIP_SHIFT +: SET_IDX_W];

   // Take the remainder and correct it once
   assign back_prod = (MOD_W+SET_IDX_W)'(quot_ff) * (MOD_W+SET_IDX_W)'(SET_COUNT);
   assign rem_raw   = MOD_W'(set_ff) - back_prod[MOD_W-1:0];
   assign rem_fix   = (rem_raw >= SET_COUNT) ? (rem_raw - SET_COUNT) : rem_raw;

   assign push_valid        = hold_valid_ff;
   assign push_data.command = cmd_ff;
   assign push_data.set     = rem_fix[SET_W-1:0];
   assign push_data.way     = way_ff;
   assign push_data.tier    = tier_ff;
   assign push_data.way_ok  = (32'(way_ff) < NUM_WAYS);

   // Accept a new word when the holding stage is empty or drains now
   assign req_ready     = enable & (~hold_valid_ff | push_ready);
   assign accept        = req_valid & req_ready;
   assign hold_valid_in = accept | (hold_valid_ff & ~push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Hold the payload of the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         set_ff  <= req_set_index;
         way_ff  <= req_way_index;
         tier_ff <= req_tier;
         quot_ff <= quot_in;
      end
   end

endmodule

// ===== sv/trrip_queue.sv =====
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module trrip_queue import trrip_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_data
);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Advance the pointers, wrapping at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/trrip_back.sv =====
// Back end: row store, read-modify-write of one set, victim search and result register.
`timescale 1ns / 1ps

module trrip_back import trrip_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [RRPV_W-1:0]     evict_level,
   output logic                  clearing,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  item_type              pop_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WAY_IDX_W-1:0]  rsp_victim_way,
   output logic [RRPV_W-1:0]     rsp_new_value
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   row_type                rrpv_mem [NUM_SETS];

   logic [1:0]             state_ff, state_in;
   logic [SET_W-1:0]       clr_ff, clr_in;
   item_type               cur_ff;
   row_type                rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WAY_IDX_W-1:0]   rsp_way_ff, rsp_way_in;
   logic [RRPV_W-1:0]      rsp_value_ff, rsp_value_in;

   logic                   out_free;
   logic                   rd_en;
   logic                   wr_en;
   logic [SET_W-1:0]       wr_addr;
   row_type                wr_data;

   logic [RRPV_W*3-1:0]    therm_or;
   logic [RRPV_W-1:0]      highest;
   logic                   below;
   logic [RRPV_W-1:0]      thresh;
   logic [RRPV_W-1:0]      step;
   row_type                aged;
   logic [WAY_W-1:0]       victim;
   logic [RRPV_W-1:0]      victim_value;
   logic [WAY_W-1:0]       way_sel;
   logic [RRPV_W-1:0]      old_value;
   logic [RRPV_W-1:0]      fill_value;
   logic [RRPV_W-1:0]      upd_value;
   row_type                upd_row;
   logic                   exec_go;

   assign clearing  = (state_ff == ST_CLEAR);
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign rd_en     = pop_valid & pop_ready;
   assign exec_go   = (state_ff == ST_EXEC) & out_free;

   // Victim search: highest value as a thermometer OR over the ways
   always_comb begin
      therm_or = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         for (int v = 1; v <= RRPV_W*3 - 1 + 1; v++) begin
            if (32'(rd_data_ff[w]) >= v) begin
               therm_or[v-1] = 1'b1;
            end
         end
      end
      highest = RRPV_W'($countones(therm_or));
      below   = (highest < evict_level);
      thresh  = below ? highest : evict_level;
      step    = evict_level - highest;
   end

   // When no way reaches the eviction level, age every way by the gap; pick the first way at or above the threshold
   always_comb begin
      victim = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged[w] = (below && (rd_data_ff[w] < evict_level)) ? rd_data_ff[w] + step
                                                             : rd_data_ff[w];
      end
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (rd_data_ff[w] >= thresh) begin
            victim = WAY_W'(w);
         end
      end
      victim_value = below ? evict_level : rd_data_ff[victim];
   end

   // Update of a single addressed way
   always_comb begin
      way_sel   = WAY_W'(cur_ff.way);
      old_value = rd_data_ff[way_sel];
      case (cur_ff.tier)
         TIER_HIGH: fill_value = RRPV_HIGH_FILL;
         TIER_MOD:  fill_value = (evict_level == '0) ? '0 : evict_level - 1'b1;
         default:   fill_value = evict_level;
      endcase
      unique case (cur_ff.command)
         CMD_FILL: upd_value = fill_value;
         CMD_HIT: begin
            if (cur_ff.tier == TIER_HIGH) begin
               upd_value = '0;
            end else begin
               upd_value = (old_value == '0) ? '0 : old_value - 1'b1;
            end
         end
         CMD_INVAL: upd_value = evict_level;
         default:   upd_value = old_value;
      endcase
      upd_row          = rd_data_ff;
      upd_row[way_sel] = upd_value;
   end

   // Select write-back and result
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = cur_ff.set;
      wr_data      = upd_row;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_way_in   = rsp_way_ff;
      rsp_value_in = rsp_value_ff;
      if (clearing) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = {NUM_WAYS{RRPV_RESET}};
      end else if (exec_go) begin
         rsp_valid_in = 1'b1;
         if (cur_ff.command == CMD_VICTIM) begin
            wr_en        = 1'b1;
            wr_data      = aged;
            rsp_way_in   = WAY_IDX_W'(victim);
            rsp_value_in = victim_value;
         end else begin
            wr_en        = cur_ff.way_ok;
            rsp_way_in   = cur_ff.way;
            rsp_value_in = cur_ff.way_ok ? upd_value : '0;
         end
      end
   end

   // Sequence: clear the store, then read a set and write it back
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (rd_en) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the word under work and the result payload
   always_ff @(posedge clock) begin
      if (rd_en) begin
         cur_ff <= pop_data;
      end
      rsp_way_ff   <= rsp_way_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Row store: one registered read, one write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rrpv_mem[pop_data.set];
      end
      if (wr_en) begin
         rrpv_mem[wr_addr] <= wr_data;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_victim_way = rsp_way_ff;
   assign rsp_new_value  = rsp_value_ff;

endmodule

// ===== sv/tiered_rrip_replacement.sv =====
// Top level of the tiered RRIP replacement block: register port, front, queue and back.
`timescale 1ns / 1ps

// Keeps a 3-bit re-reference prediction value for every way of every set and
// serves fill, hit, invalidate and find-victim commands, one result word per
// command, in order. The back end works on one command at a time: it first
// reads the set's row from the row store into a register, then updates or
// ages it, searches for the victim and writes it back, and takes no new
// command until it has written the row and moved the result to its register.
// The front end reduces the set index and checks the way, and a two-word
// queue lets it keep taking commands while a result waits to be taken.
// After reset the back end clears the row store to value 7, one set per
// cycle, through all NUM_SETS (1024) sets; no command is taken during that
// pass, though the eviction level may be written. The eviction level sits
// at byte address 0 and should be written only while the block is idle.
module tiered_rrip_replacement import trrip_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CMD_W-1:0]       req_command,
   input  logic [SET_IDX_W-1:0]   req_set_index,
   input  logic [WAY_IDX_W-1:0]   req_way_index,
   input  logic [TIER_W-1:0]      req_tier,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WAY_IDX_W-1:0]   rsp_victim_way,
   output logic [RRPV_W-1:0]      rsp_new_value,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic [RRPV_W-1:0] evict_level_ff, evict_level_in;
   logic              csr_wr;
   logic              clearing;
   logic              push_valid;
   logic              push_ready;
   item_type          push_data;
   logic              pop_valid;
   logic              pop_ready;
   item_type          pop_data;

   // Register port: write on the access cycle, read back the level
   assign csr_pready     = 1'b1;
   assign csr_wr         = csr_psel & csr_penable & csr_pwrite & csr_pready
                           & (csr_paddr == CSR_ADDR_EVICT_LEVEL);
   assign evict_level_in = csr_wr ? csr_pwdata[RRPV_W-1:0] : evict_level_ff;
   assign csr_prdata     = (csr_paddr == CSR_ADDR_EVICT_LEVEL) ?
                           CSR_DATA_W'(evict_level_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         evict_level_ff <= RRPV_RESET;
      end else begin
         evict_level_ff <= evict_level_in;
      end
   end

   trrip_front u_front (
      .clock         (clock),
      .reset         (reset),
      .enable        (~clearing),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_set_index (req_set_index),
      .req_way_index (req_way_index),
      .req_tier      (req_tier),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   trrip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   trrip_back u_back (
      .clock          (clock),
      .reset          (reset),
      .evict_level    (evict_level_ff),
      .clearing       (clearing),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_victim_way (rsp_victim_way),
      .rsp_new_value  (rsp_new_value)
   );

endmodule
